@@ src/htfc_pkg.sv @@
// ----------------------------------------------------------------------------
// htfc_pkg - shared types and constants of the sensor frame checker
// Frame layout, CRC-16 constants and byte fold, configuration indexes, status codes and the result record.
// ----------------------------------------------------------------------------
package htfc_pkg;

  // Frame layout
  localparam int unsigned PosW = 3;
  localparam logic [PosW-1:0] PosFunc     = 3'd0;
  localparam logic [PosW-1:0] PosCount    = 3'd1;
  localparam logic [PosW-1:0] PosHumHi    = 3'd2;
  localparam logic [PosW-1:0] PosHumLo    = 3'd3;
  localparam logic [PosW-1:0] PosTempHi   = 3'd4;
  localparam logic [PosW-1:0] PosTempLo   = 3'd5;
  localparam logic [PosW-1:0] PosCrcLo    = 3'd6;
  localparam logic [PosW-1:0] PosCrcHi    = 3'd7;

  // CRC-16, reflected
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgFuncCode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRegCount = 2'd1;
  localparam logic [7:0] FuncCodeReset = 8'h03;
  localparam logic [7:0] RegCountReset = 8'h04;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_HEADER_BAD = 2'd1,
    STATUS_CRC_BAD    = 2'd2
  } status_e;

  typedef struct packed {
    status_e            status;
    logic        [15:0] humidity;
    logic signed [15:0] temperature;
  } result_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/htfc_frame_core.sv @@
// ----------------------------------------------------------------------------
// htfc_frame_core - byte position tracking, CRC and field decode
// Holds the per-frame state and forms the result on the last frame byte.
// ----------------------------------------------------------------------------
module htfc_frame_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  frame_start_i,
  input  logic [7:0]            exp_func_i,
  input  logic [7:0]            exp_count_i,
  output logic                  res_valid_o,
  output htfc_pkg::result_t     res_o
);

  logic [htfc_pkg::PosW-1:0] pos_q, pos_d, pos_eff;
  logic [15:0]               crc_q, crc_d, crc_base;
  logic                      hdr_bad_q, hdr_bad_d, hdr_base;
  logic [15:0]               hum_q, hum_d;
  logic [15:0]               temp_q, temp_d;
  logic [7:0]                crc_lo_q, crc_lo_d;
  logic [15:0]               received;
  logic [14:0]               mag;

  // Restart position, CRC and header flag on a start flag
  always_comb begin
    pos_eff  = frame_start_i ? htfc_pkg::PosFunc : pos_q;
    crc_base = frame_start_i ? htfc_pkg::CrcInit : crc_q;
    hdr_base = frame_start_i ? 1'b0 : hdr_bad_q;
  end

  // Next state and result for the accepted item
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    hdr_bad_d   = hdr_bad_q;
    hum_d       = hum_q;
    temp_d      = temp_q;
    crc_lo_d    = crc_lo_q;
    res_valid_o = 1'b0;
    received    = {rx_byte_i, crc_lo_q};
    mag         = temp_q[14:0];

    res_o.status      = htfc_pkg::STATUS_OK;
    res_o.humidity    = hum_q;
    res_o.temperature = temp_q[15] ? $signed(16'h0000 - {1'b0, mag})
                                   : $signed({1'b0, mag});
    if (hdr_base) begin
      res_o.status = htfc_pkg::STATUS_HEADER_BAD;
    end else if (received != crc_base) begin
      res_o.status = htfc_pkg::STATUS_CRC_BAD;
    end
    if (res_o.status != htfc_pkg::STATUS_OK) begin
      res_o.humidity    = 16'h0000;
      res_o.temperature = 16'sh0000;
    end

    if (accept_i) begin
      crc_d     = (pos_eff < htfc_pkg::PosCrcLo) ? htfc_pkg::crc_byte(crc_base, rx_byte_i)
                                                 : crc_base;
      hdr_bad_d = hdr_base;
      pos_d     = pos_eff + 3'd1;
      case (pos_eff)
        htfc_pkg::PosFunc:   hdr_bad_d = hdr_base | (rx_byte_i != exp_func_i);
        htfc_pkg::PosCount:  hdr_bad_d = hdr_base | (rx_byte_i != exp_count_i);
        htfc_pkg::PosHumHi:  hum_d[15:8]  = rx_byte_i;
        htfc_pkg::PosHumLo:  hum_d[7:0]   = rx_byte_i;
        htfc_pkg::PosTempHi: temp_d[15:8] = rx_byte_i;
        htfc_pkg::PosTempLo: temp_d[7:0]  = rx_byte_i;
        htfc_pkg::PosCrcLo:  crc_lo_d     = rx_byte_i;
        htfc_pkg::PosCrcHi: begin
          res_valid_o = 1'b1;
          pos_d       = htfc_pkg::PosFunc;
          crc_d       = htfc_pkg::CrcInit;
          hdr_bad_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= htfc_pkg::PosFunc;
      crc_q     <= htfc_pkg::CrcInit;
      hdr_bad_q <= 1'b0;
      hum_q     <= 16'h0000;
      temp_q    <= 16'h0000;
      crc_lo_q  <= 8'h00;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      hdr_bad_q <= hdr_bad_d;
      hum_q     <= hum_d;
      temp_q    <= temp_d;
      crc_lo_q  <= crc_lo_d;
    end
  end

endmodule

@@ src/htfc_out_reg.sv @@
// ----------------------------------------------------------------------------
// htfc_out_reg - result register
// Holds one result item until taken and gives back-pressure upstream.
// ----------------------------------------------------------------------------
module htfc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  htfc_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output htfc_pkg::result_t res_o,
  output logic              in_ready_o
);

  logic              valid_q, valid_d;
  htfc_pkg::result_t res_q;

  // Free when empty or being drained this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ src/humidity_temp_frame_checker.sv @@
// A result is shown in the cycle after the eighth byte of a frame is accepted.
// Throughput: one byte per cycle while in_ready_o is high; the CRC byte update is an unrolled combinational step.
// in_ready_o drops only while a result waits in the output register and out_ready_i is low.
// Reset (rst_ni low, asynchronous): position 0, CRC 0xFFFF, header flag clear, output empty,
// expected function code 3 and expected register count 4.
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker - sensor reply frame checker
// Checks header and CRC-16 of an 8-byte reply and decodes humidity and
// temperature in tenths.
// ----------------------------------------------------------------------------
module humidity_temp_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [htfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    frame_status_o,
  output logic [15:0]                   humidity_tenths_o,
  output logic signed [15:0]            temperature_tenths_o
);

  logic [7:0]        exp_func_q, exp_count_q;
  logic              accept;
  logic              res_valid;
  htfc_pkg::result_t res, res_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_func_q  <= htfc_pkg::FuncCodeReset;
      exp_count_q <= htfc_pkg::RegCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        htfc_pkg::CfgFuncCode: exp_func_q  <= cfg_wdata_i;
        htfc_pkg::CfgRegCount: exp_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  htfc_frame_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .exp_func_i    (exp_func_q),
    .exp_count_i   (exp_count_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  htfc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .in_ready_o  (in_ready_o)
  );

  assign frame_status_o       = res_out.status;
  assign humidity_tenths_o    = res_out.humidity;
  assign temperature_tenths_o = res_out.temperature;

endmodule

@@ src/htfc_checker.sv @@
// ----------------------------------------------------------------------------
// htfc_checker - port-level assertions for the frame checker
// Watches handshakes and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module htfc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         frame_status_o,
  input logic [15:0]        humidity_tenths_o,
  input logic signed [15:0] temperature_tenths_o
);

  // Stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A waiting result blocks new bytes
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while result stalled");

  // A new result follows an accepted byte
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result item without an accepted byte");

  // Error results carry zero readings
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != htfc_pkg::STATUS_OK)
      |-> (humidity_tenths_o == 16'h0000) && (temperature_tenths_o == 16'sh0000))
    else $error("error result with non-zero readings");

endmodule

bind humidity_temp_frame_checker htfc_checker u_htfc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .frame_status_o       (frame_status_o),
  .humidity_tenths_o    (humidity_tenths_o),
  .temperature_tenths_o (temperature_tenths_o)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the sensor reply frame checker
// Feeds reply bytes over the input handshake: first a short table of frames,
// then random frames, cut-off frames and noise under four register settings.
// A shadow frame tracker predicts every result, and each result leaving the
// block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned   DrainCycles = 6;
  localparam longint        TimeoutNs   = 5_000_000;
  localparam int unsigned   ResetCycles = 11;
  // indexes the block does not decode
  localparam logic [htfc_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [htfc_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;
  localparam htfc_pkg::result_t NoResult = '{htfc_pkg::STATUS_OK, 16'h0000, 16'sh0000};

  // one directed frame: header, raw words, CRC corruption, length, start flag
  typedef struct packed {
    logic [7:0]        func;
    logic [7:0]        count;
    logic [15:0]       hum;
    logic [15:0]       temp;
    logic [15:0]       crc_flip;
    logic [3:0]        nbytes;
    logic              start;
    logic              typed;
    htfc_pkg::result_t res;
  } frame_row_t;

  localparam frame_row_t DirRows [4] = '{
    // first frame after reset without a start flag; negative zero, humidity max
    '{8'h03, 8'h04, 16'hFFFF, 16'h8000, 16'h0000, 4'd8, 1'b0, 1'b1,
      '{htfc_pkg::STATUS_OK, 16'hFFFF, 16'sh0000}},
    // lone byte, then dropped by the next start flag
    '{8'hFF, 8'h00, 16'h0000, 16'h0000, 16'h0000, 4'd1, 1'b1, 1'b0, NoResult},
    // CRC mismatch zeroes the decoded fields
    '{8'h03, 8'h04, 16'h0000, 16'hFFFF, 16'h8000, 4'd8, 1'b1, 1'b1,
      '{htfc_pkg::STATUS_CRC_BAD, 16'h0000, 16'sh0000}},
    // back to back, header and CRC both bad: header wins
    '{8'h00, 8'hFF, 16'h1234, 16'h7FFF, 16'h0001, 4'd8, 1'b0, 1'b1,
      '{htfc_pkg::STATUS_HEADER_BAD, 16'h0000, 16'sh0000}}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [htfc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [7:0]                   cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [7:0]                   rx_byte_i;
  logic                         frame_start_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [1:0]                   frame_status_o;
  logic [15:0]                  humidity_tenths_o;
  logic signed [15:0]           temperature_tenths_o;

  // shadow of the block's frame state and registers
  logic [htfc_pkg::PosW-1:0] frm_pos;
  logic [15:0]               frm_crc;
  logic                      frm_hdr_bad;
  logic [15:0]               frm_hum_raw;
  logic [15:0]               frm_temp_raw;
  logic [7:0]                frm_crc_lo;
  logic [7:0]                func_code_cfg;
  logic [7:0]                reg_count_cfg;

  htfc_pkg::result_t frame_results_q [$];

  logic in_gaps_on;
  logic out_stalls_on;
  int   fail_count;
  int   bytes_sent;
  int   results_seen;
  int   ok_seen;
  int   hdr_seen;
  int   crc_seen;

  humidity_temp_frame_checker u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .rx_byte_i            (rx_byte_i),
    .frame_start_i        (frame_start_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .frame_status_o       (frame_status_o),
    .humidity_tenths_o    (humidity_tenths_o),
    .temperature_tenths_o (temperature_tenths_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // CRC-16 reflected, one data bit folded in per shift
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ htfc_pkg::CrcPoly;
      end
    end
    return c;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // raw sensor word, biased towards the extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // advance the shadow tracker by one accepted byte; queue the frame result
  task automatic track_frame_byte(input logic [7:0] b, input logic s,
                                  input logic typed, input htfc_pkg::result_t typed_res);
    htfc_pkg::result_t r;
    logic [15:0]       rx_crc;
    logic [15:0]       mag;
    if (s) begin
      frm_pos     = htfc_pkg::PosFunc;
      frm_crc     = htfc_pkg::CrcInit;
      frm_hdr_bad = 1'b0;
    end
    if (frm_pos < htfc_pkg::PosCrcLo) begin
      frm_crc = crc16_fold(frm_crc, b);
    end
    case (frm_pos)
      htfc_pkg::PosFunc:   if (b != func_code_cfg) frm_hdr_bad = 1'b1;
      htfc_pkg::PosCount:  if (b != reg_count_cfg) frm_hdr_bad = 1'b1;
      htfc_pkg::PosHumHi:  frm_hum_raw[15:8]  = b;
      htfc_pkg::PosHumLo:  frm_hum_raw[7:0]   = b;
      htfc_pkg::PosTempHi: frm_temp_raw[15:8] = b;
      htfc_pkg::PosTempLo: frm_temp_raw[7:0]  = b;
      htfc_pkg::PosCrcLo:  frm_crc_lo         = b;
      default: ;
    endcase
    if (frm_pos == htfc_pkg::PosCrcHi) begin
      rx_crc = {b, frm_crc_lo};
      r      = NoResult;
      if (frm_hdr_bad) begin
        r.status = htfc_pkg::STATUS_HEADER_BAD;
      end else if (rx_crc != frm_crc) begin
        r.status = htfc_pkg::STATUS_CRC_BAD;
      end else begin
        // sign-magnitude to two's complement
        mag           = {1'b0, frm_temp_raw[14:0]};
        r.status      = htfc_pkg::STATUS_OK;
        r.humidity    = frm_hum_raw;
        r.temperature = frm_temp_raw[15] ? 16'h0000 - mag : mag;
      end
      frame_results_q.push_back(typed ? typed_res : r);
      frm_pos     = htfc_pkg::PosFunc;
      frm_crc     = htfc_pkg::CrcInit;
      frm_hdr_bad = 1'b0;
    end else begin
      frm_pos = frm_pos + 1'b1;
    end
  endtask

  // offer one byte from a falling edge, hold until accepted
  task automatic push_byte(input logic [7:0] b, input logic s,
                           input logic typed, input htfc_pkg::result_t typed_res);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    track_frame_byte(b, s, typed, typed_res);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // build a reply with its CRC (optionally corrupted) and send its first nbytes
  task automatic send_frame(input logic [7:0] fc, input logic [7:0] rc,
                            input logic [15:0] hum, input logic [15:0] temp,
                            input logic [15:0] crc_flip, input logic [3:0] nbytes,
                            input logic first_start, input logic typed,
                            input htfc_pkg::result_t typed_res);
    logic [7:0]  fb [8];
    logic [15:0] c;
    fb[0] = fc;
    fb[1] = rc;
    fb[2] = hum[15:8];
    fb[3] = hum[7:0];
    fb[4] = temp[15:8];
    fb[5] = temp[7:0];
    c = htfc_pkg::CrcInit;
    for (int i = 0; i < 6; i++) begin
      c = crc16_fold(c, fb[i]);
    end
    c     = c ^ crc_flip;
    fb[6] = c[7:0];
    fb[7] = c[15:8];
    for (int i = 0; i < int'(nbytes); i++) begin
      push_byte(fb[i], (i == 0) ? first_start : 1'b0, typed && (i == 7), typed_res);
    end
  endtask

  // drop valid, wait for every queued result, then let the pipeline settle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // one register write, only while idle
  task automatic write_cfg(input logic [htfc_pkg::CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      htfc_pkg::CfgFuncCode: func_code_cfg = data;
      htfc_pkg::CfgRegCount: reg_count_cfg = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // mostly well-formed frames with random content; the rest cut off or noise
  task automatic run_random(input int target);
    int         first;
    int         kind;
    int         n;
    logic [7:0] fc;
    logic [7:0] rc;
    first = bytes_sent;
    while (bytes_sent - first < target) begin
      kind = $urandom_range(0, 99);
      fc   = ($urandom_range(0, 9) < 8) ? func_code_cfg : 8'($urandom_range(0, 255));
      rc   = ($urandom_range(0, 9) < 8) ? reg_count_cfg : 8'($urandom_range(0, 255));
      if (kind < 70) begin
        send_frame(fc, rc, pick_word(), pick_word(),
                   ($urandom_range(0, 9) < 8) ? 16'h0000 : 16'($urandom_range(1, 65535)),
                   4'd8, (frm_pos == htfc_pkg::PosFunc) ? 1'($urandom_range(0, 1)) : 1'b1,
                   1'b0, NoResult);
      end else if (kind < 85) begin
        send_frame(fc, rc, pick_word(), pick_word(), 16'h0000,
                   4'($urandom_range(1, 7)), 1'b1, 1'b0, NoResult);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, NoResult);
        end
      end
    end
  endtask

  // result side back-pressure
  initial begin
    int hold;
    int g;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (!out_stalls_on) begin
        out_ready_i <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready_i <= 1'b1;
          hold = $urandom_range(0, 7);
        end else begin
          out_ready_i <= 1'b0;
          hold = g - 1;
        end
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    htfc_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_q.size() == 0) begin
        $error("result with no prediction: status %0d humidity %0d temperature %0d",
               frame_status_o, humidity_tenths_o, temperature_tenths_o);
        fail_count++;
      end else begin
        want = frame_results_q.pop_front();
        results_seen++;
        case (want.status)
          htfc_pkg::STATUS_OK:         ok_seen++;
          htfc_pkg::STATUS_HEADER_BAD: hdr_seen++;
          default:                     crc_seen++;
        endcase
        if (frame_status_o !== want.status) begin
          $error("frame_status mismatch: expected %0d, got %0d", want.status, frame_status_o);
          fail_count++;
        end
        if (humidity_tenths_o !== want.humidity) begin
          $error("humidity_tenths mismatch: expected %0d, got %0d",
                 want.humidity, humidity_tenths_o);
          fail_count++;
        end
        if (temperature_tenths_o !== want.temperature) begin
          $error("temperature_tenths mismatch: expected %0d, got %0d",
                 want.temperature, temperature_tenths_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    frame_row_t row;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = htfc_pkg::CfgFuncCode;
    cfg_wdata_i   = 8'h00;
    in_valid_i    = 1'b0;
    rx_byte_i     = 8'h00;
    frame_start_i = 1'b0;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    fail_count    = 0;
    bytes_sent    = 0;
    results_seen  = 0;
    ok_seen       = 0;
    hdr_seen      = 0;
    crc_seen      = 0;
    frm_pos       = htfc_pkg::PosFunc;
    frm_crc       = htfc_pkg::CrcInit;
    frm_hdr_bad   = 1'b0;
    frm_hum_raw   = 16'h0000;
    frm_temp_raw  = 16'h0000;
    frm_crc_lo    = 8'h00;
    func_code_cfg = htfc_pkg::FuncCodeReset;
    reg_count_cfg = htfc_pkg::RegCountReset;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table, reset register values, no idling
    for (int i = 0; i < $size(DirRows); i++) begin
      row = DirRows[i];
      send_frame(row.func, row.count, row.hum, row.temp, row.crc_flip, row.nbytes,
                 row.start, row.typed, row.res);
    end
    // hold the sender until every result has drained
    settle();

    // reset register values with idling on both sides
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    run_random(100);
    settle();

    // low and high extremes
    write_cfg(htfc_pkg::CfgFuncCode, 8'h00);
    write_cfg(htfc_pkg::CfgRegCount, 8'hFF);
    run_random(100);
    settle();

    // swapped extremes; spare indexes must be ignored
    write_cfg(htfc_pkg::CfgFuncCode, 8'hFF);
    write_cfg(htfc_pkg::CfgRegCount, 8'h00);
    write_cfg(CfgSpareA, 8'($urandom_range(0, 255)));
    write_cfg(CfgSpareB, 8'($urandom_range(0, 255)));
    run_random(100);
    settle();

    // random values, full rate on both sides
    write_cfg(htfc_pkg::CfgFuncCode, 8'($urandom_range(0, 255)));
    write_cfg(htfc_pkg::CfgRegCount, 8'($urandom_range(0, 255)));
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    run_random(100);
    settle();

    $display("Sent %0d reply bytes over four register settings, with cut-off frames,",
             bytes_sent);
    $display("noise and mid-frame restarts; checked %0d results (%0d ok, %0d header, %0d crc).",
             results_seen, ok_seen, hdr_seen, crc_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
